// ----- rtl/core/lfpd_pkg.sv -----
package lfpd_pkg;

  // field widths
  localparam int POS_W      = 11;
  localparam int ERR_W      = 11;
  localparam int GAIN_W     = 16;
  localparam int BASE_W     = 8;
  localparam int ANGLE_W    = 8;
  localparam int CORR_W     = 16;
  localparam int FRAC_W     = 8;

  // stream packing
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // defaults and fixed values
  localparam int CENTER_POSITION_DEF = 1000;
  localparam int INTEG_LIMIT_DEF     = 10000;
  localparam int ANGLE_MAX           = 180;
  localparam int BASE_RESET          = 115;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_LEFT_BASE  = 3'd3,
    REG_RIGHT_BASE = 3'd4
  } cfg_reg_t;

endpackage

// ----- rtl/core/lfpd_front.sv -----
module lfpd_front #(
  parameter int CENTER_POSITION  = lfpd_pkg::CENTER_POSITION_DEF,
  parameter int INTEGRATOR_LIMIT = lfpd_pkg::INTEG_LIMIT_DEF,
  parameter int INTEG_W          = $clog2(lfpd_pkg::INTEG_LIMIT_DEF + 1) + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lfpd_pkg::POS_W-1:0]        position,
  output logic                              s1_valid,
  input  logic                              s1_ready,
  output logic signed [lfpd_pkg::ERR_W-1:0] s1_err,
  output logic signed [lfpd_pkg::ERR_W:0]   s1_derr,
  output logic signed [INTEG_W-1:0]         s1_integ
);
  import lfpd_pkg::*;

  localparam int CEN_W  = $clog2(CENTER_POSITION + 1);
  localparam int DIFF_W = ((CEN_W > POS_W) ? CEN_W : POS_W) + 1;
  localparam int IA_W   = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
  localparam int ERR_MAX = 2 ** (ERR_W - 1) - 1;
  localparam int ERR_MIN = -(2 ** (ERR_W - 1));

  logic                     accept;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ERR_W-1:0]  err;
  logic signed [IA_W-1:0]   isum;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [ERR_W:0]    derr;

  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   prior_r;
  logic                      s1_valid_r;
  logic signed [ERR_W-1:0]   s1_err_r;
  logic signed [ERR_W:0]     s1_derr_r;
  logic signed [INTEG_W-1:0] s1_integ_r;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  // error, saturated to the error field range
  always_comb begin
    diff = $signed({{(DIFF_W-POS_W){1'b0}}, position}) - $signed(DIFF_W'(CENTER_POSITION));
    if (diff > $signed(DIFF_W'(ERR_MAX))) begin
      err = ERR_W'(ERR_MAX);
    end else if (diff < $signed(DIFF_W'(ERR_MIN))) begin
      err = ERR_W'(ERR_MIN);
    end else begin
      err = diff[ERR_W-1:0];
    end
  end

  // clamped integrator
  always_comb begin
    isum = $signed({{(IA_W-INTEG_W){integ_r[INTEG_W-1]}}, integ_r})
         + $signed({{(IA_W-ERR_W){err[ERR_W-1]}}, err});
    if (isum > $signed(IA_W'(INTEGRATOR_LIMIT))) begin
      integ_nxt = INTEG_W'(INTEGRATOR_LIMIT);
    end else if (isum < -$signed(IA_W'(INTEGRATOR_LIMIT))) begin
      integ_nxt = -$signed(INTEG_W'(INTEGRATOR_LIMIT));
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  assign derr = $signed({err[ERR_W-1], err}) - $signed({prior_r[ERR_W-1], prior_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prior_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        integ_r <= integ_nxt;
        prior_r <= err;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err_r   <= err;
      s1_derr_r  <= derr;
      s1_integ_r <= integ_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_err   = s1_err_r;
  assign s1_derr  = s1_derr_r;
  assign s1_integ = s1_integ_r;

`ifndef ASSERT_OFF
  a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (integ_r <= $signed(INTEG_W'(INTEGRATOR_LIMIT)))
            && (integ_r >= -$signed(INTEG_W'(INTEGRATOR_LIMIT))))
    else $error("integrator left its clamp range");
  a_prior_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (prior_r == s1_err_r) && (integ_r == s1_integ_r))
    else $error("stored state differs from the staged sample");
`endif

endmodule

// ----- rtl/core/lfpd_mult.sv -----
module lfpd_mult #(
  parameter int INTEG_W = $clog2(lfpd_pkg::INTEG_LIMIT_DEF + 1) + 1
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          s1_valid,
  output logic                                          s1_ready,
  input  logic signed [lfpd_pkg::ERR_W-1:0]             s1_err,
  input  logic signed [lfpd_pkg::ERR_W:0]               s1_derr,
  input  logic signed [INTEG_W-1:0]                     s1_integ,
  input  logic signed [lfpd_pkg::GAIN_W-1:0]            prop_gain,
  input  logic signed [lfpd_pkg::GAIN_W-1:0]            integ_gain,
  input  logic signed [lfpd_pkg::GAIN_W-1:0]            deriv_gain,
  output logic                                          s2_valid,
  input  logic                                          s2_ready,
  output logic signed [lfpd_pkg::GAIN_W+lfpd_pkg::ERR_W-1:0] s2_prop,
  output logic signed [lfpd_pkg::GAIN_W+lfpd_pkg::ERR_W:0]   s2_deriv,
  output logic signed [lfpd_pkg::GAIN_W+INTEG_W-1:0]         s2_integ
);
  import lfpd_pkg::*;

  logic signed [GAIN_W+ERR_W-1:0]   prop_nxt;
  logic signed [GAIN_W+ERR_W:0]     deriv_nxt;
  logic signed [GAIN_W+INTEG_W-1:0] integ_nxt;

  logic                             s2_valid_r;
  logic signed [GAIN_W+ERR_W-1:0]   s2_prop_r;
  logic signed [GAIN_W+ERR_W:0]     s2_deriv_r;
  logic signed [GAIN_W+INTEG_W-1:0] s2_integ_r;

  assign s1_ready = !s2_valid_r || s2_ready;

  // three products in parallel, each registered
  assign prop_nxt  = prop_gain * s1_err;
  assign deriv_nxt = deriv_gain * s1_derr;
  assign integ_nxt = integ_gain * s1_integ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2_prop_r  <= prop_nxt;
      s2_deriv_r <= deriv_nxt;
      s2_integ_r <= integ_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_prop  = s2_prop_r;
  assign s2_deriv = s2_deriv_r;
  assign s2_integ = s2_integ_r;

endmodule

// ----- rtl/core/lfpd_out.sv -----
module lfpd_out #(
  parameter int INTEG_W = $clog2(lfpd_pkg::INTEG_LIMIT_DEF + 1) + 1
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               s2_valid,
  output logic                                               s2_ready,
  input  logic signed [lfpd_pkg::GAIN_W+lfpd_pkg::ERR_W-1:0] s2_prop,
  input  logic signed [lfpd_pkg::GAIN_W+lfpd_pkg::ERR_W:0]   s2_deriv,
  input  logic signed [lfpd_pkg::GAIN_W+INTEG_W-1:0]         s2_integ,
  input  logic [lfpd_pkg::BASE_W-1:0]                        left_base,
  input  logic [lfpd_pkg::BASE_W-1:0]                        right_base,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [lfpd_pkg::ANGLE_W-1:0]                       left_angle,
  output logic [lfpd_pkg::ANGLE_W-1:0]                       right_angle,
  output logic signed [lfpd_pkg::CORR_W-1:0]                 correction
);
  import lfpd_pkg::*;

  localparam int PD_W   = GAIN_W + ERR_W + 1;
  localparam int PI_W   = GAIN_W + INTEG_W;
  localparam int SUM_W  = ((PD_W > PI_W) ? PD_W : PI_W) + 2;
  localparam int AW     = CORR_W + 2;
  localparam int CORR_MAX = 2 ** (CORR_W - 1) - 1;
  localparam int CORR_MIN = -(2 ** (CORR_W - 1));
  localparam int ROUND_ADD = 2 ** FRAC_W - 1;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_adj;
  logic signed [SUM_W-1:0]  quo;
  logic signed [CORR_W-1:0] corr;
  logic signed [AW-1:0]     corr_x;
  logic signed [AW-1:0]     left_raw;
  logic signed [AW-1:0]     right_raw;
  logic [ANGLE_W-1:0]       left_nxt;
  logic [ANGLE_W-1:0]       right_nxt;

  logic                     out_valid_r;
  logic [ANGLE_W-1:0]       left_r;
  logic [ANGLE_W-1:0]       right_r;
  logic signed [CORR_W-1:0] corr_r;

  assign s2_ready = !out_valid_r || out_ready;

  // sum, divide by 256 rounding toward zero, saturate
  always_comb begin
    sum = $signed({{(SUM_W-(GAIN_W+ERR_W)){s2_prop[GAIN_W+ERR_W-1]}}, s2_prop})
        + $signed({{(SUM_W-PD_W){s2_deriv[PD_W-1]}}, s2_deriv})
        + $signed({{(SUM_W-PI_W){s2_integ[PI_W-1]}}, s2_integ});
    sum_adj = sum + (sum[SUM_W-1] ? $signed(SUM_W'(ROUND_ADD)) : $signed(SUM_W'(0)));
    quo     = sum_adj >>> FRAC_W;
    if (quo > $signed(SUM_W'(CORR_MAX))) begin
      corr = CORR_W'(CORR_MAX);
    end else if (quo < $signed(SUM_W'(CORR_MIN))) begin
      corr = CORR_W'(CORR_MIN);
    end else begin
      corr = quo[CORR_W-1:0];
    end
  end

  // wheel angles, clamped to the servo range
  always_comb begin
    corr_x    = $signed({{(AW-CORR_W){corr[CORR_W-1]}}, corr});
    left_raw  = $signed({{(AW-BASE_W){1'b0}}, left_base}) - corr_x;
    right_raw = $signed(AW'(ANGLE_MAX)) - $signed({{(AW-BASE_W){1'b0}}, right_base}) - corr_x;
    if (left_raw < $signed(AW'(0))) begin
      left_nxt = '0;
    end else if (left_raw > $signed(AW'(ANGLE_MAX))) begin
      left_nxt = ANGLE_W'(ANGLE_MAX);
    end else begin
      left_nxt = left_raw[ANGLE_W-1:0];
    end
    if (right_raw < $signed(AW'(0))) begin
      right_nxt = '0;
    end else if (right_raw > $signed(AW'(ANGLE_MAX))) begin
      right_nxt = ANGLE_W'(ANGLE_MAX);
    end else begin
      right_nxt = right_raw[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      corr_r  <= corr;
    end
  end

  assign out_valid   = out_valid_r;
  assign left_angle  = left_r;
  assign right_angle = right_r;
  assign correction  = corr_r;

endmodule

// ----- rtl/core/line_follow_pid_drive_top.sv -----
// PID line follower for a differential servo drive. Each in_ transaction carries one
// line-position sample (CENTER_POSITION means centred); each yields exactly one out_
// transaction with the left and right servo angles (0..180) and the saturated signed
// correction. The error is saturated to -1024..1023, the integrator clamps to
// +/- INTEGRATOR_LIMIT, the gains are signed Q8.8 and the gain sum is divided by 256
// rounding toward zero. Throughput is one transaction per clock while out_tready stays
// high; each sample passes the stage one, stage two and output registers in turn
// before its out_ transaction is offered. Stage one forms the error and updates the
// integrator and stored error (so consecutive samples chain without waiting), stage
// two holds the three gain multipliers, stage three sums, scales, saturates and
// clamps into the output register. Each stage only stalls when the one after it is
// full and held. Registers: 0 prop_gain, 1 integ_gain, 2 deriv_gain, 3 left_base,
// 4 right_base; write them only while no sample is in flight.
module line_follow_pid_drive_top #(
  parameter int CENTER_POSITION  = lfpd_pkg::CENTER_POSITION_DEF,
  parameter int INTEGRATOR_LIMIT = lfpd_pkg::INTEG_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lfpd_pkg::IN_DATA_W-1:0]     in_tdata,   // [10:0] position, rest zero
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lfpd_pkg::OUT_DATA_W-1:0]    out_tdata,  // [7:0] left_angle,
                                                         // [15:8] right_angle,
                                                         // [31:16] correction
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [lfpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lfpd_pkg::*;

  // integrator width follows from its clamp limit
  localparam int INTEG_W = $clog2(INTEGRATOR_LIMIT + 1) + 1;

  // configuration registers
  logic signed [GAIN_W-1:0] prop_gain_r;
  logic signed [GAIN_W-1:0] integ_gain_r;
  logic signed [GAIN_W-1:0] deriv_gain_r;
  logic [BASE_W-1:0]        left_base_r;
  logic [BASE_W-1:0]        right_base_r;

  // stage one to two
  logic                      s1_valid;
  logic                      s1_ready;
  logic signed [ERR_W-1:0]   s1_err;
  logic signed [ERR_W:0]     s1_derr;
  logic signed [INTEG_W-1:0] s1_integ;

  // stage two to three
  logic                             s2_valid;
  logic                             s2_ready;
  logic signed [GAIN_W+ERR_W-1:0]   s2_prop;
  logic signed [GAIN_W+ERR_W:0]     s2_deriv;
  logic signed [GAIN_W+INTEG_W-1:0] s2_integ;

  // result fields
  logic [ANGLE_W-1:0]       left_angle;
  logic [ANGLE_W-1:0]       right_angle;
  logic signed [CORR_W-1:0] correction;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      left_base_r  <= BASE_W'(BASE_RESET);
      right_base_r <= BASE_W'(BASE_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_LEFT_BASE:  left_base_r  <= cfg_wdata[BASE_W-1:0];
        REG_RIGHT_BASE: right_base_r <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // error, integrator and stored error
  lfpd_front #(
    .CENTER_POSITION  (CENTER_POSITION),
    .INTEGRATOR_LIMIT (INTEGRATOR_LIMIT),
    .INTEG_W          (INTEG_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .position (in_tdata[POS_W-1:0]),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_err   (s1_err),
    .s1_derr  (s1_derr),
    .s1_integ (s1_integ)
  );

  // gain products
  lfpd_mult #(
    .INTEG_W (INTEG_W)
  ) u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_err     (s1_err),
    .s1_derr    (s1_derr),
    .s1_integ   (s1_integ),
    .prop_gain  (prop_gain_r),
    .integ_gain (integ_gain_r),
    .deriv_gain (deriv_gain_r),
    .s2_valid   (s2_valid),
    .s2_ready   (s2_ready),
    .s2_prop    (s2_prop),
    .s2_deriv   (s2_deriv),
    .s2_integ   (s2_integ)
  );

  // correction and wheel angles, output register
  lfpd_out #(
    .INTEG_W (INTEG_W)
  ) u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid),
    .s2_ready    (s2_ready),
    .s2_prop     (s2_prop),
    .s2_deriv    (s2_deriv),
    .s2_integ    (s2_integ),
    .left_base   (left_base_r),
    .right_base  (right_base_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .left_angle  (left_angle),
    .right_angle (right_angle),
    .correction  (correction)
  );

  assign out_tdata = {correction, right_angle, left_angle};

`ifndef ASSERT_OFF
  a_accept_stages: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid)
    else $error("accepted sample did not reach the first stage");
  a_left_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (correction == '0) && (left_base_r <= BASE_W'(ANGLE_MAX))
      |-> left_angle == left_base_r)
    else $error("left angle differs from base with zero correction");
  a_right_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (correction == '0) && (right_base_r <= BASE_W'(ANGLE_MAX))
      |-> right_angle == BASE_W'(ANGLE_MAX) - right_base_r)
    else $error("right angle differs from mirrored base with zero correction");
`endif

endmodule
